// ----- rtl/qtd_pkg.sv -----
package qtd_pkg;

  // parse modes
  localparam logic [1:0] MODE_TYPE    = 2'd0;
  localparam logic [1:0] MODE_PAYLOAD = 2'd1;
  localparam logic [1:0] MODE_STRING  = 2'd2;
  localparam logic [1:0] MODE_ERROR   = 2'd3;

  // frame kinds
  localparam logic [1:0] FK_ARR  = 2'd0;
  localparam logic [1:0] FK_MAP  = 2'd1;
  localparam logic [1:0] FK_OARR = 2'd2;
  localparam logic [1:0] FK_OMAP = 2'd3;

  // close seek modes
  localparam logic [1:0] SEEK_ARR = 2'd0;
  localparam logic [1:0] SEEK_MAP = 2'd1;
  localparam logic [1:0] SEEK_END = 2'd2;

  // token kinds
  localparam logic [3:0] TK_INT     = 4'd0;
  localparam logic [3:0] TK_FLOAT   = 4'd1;
  localparam logic [3:0] TK_TRUE    = 4'd2;
  localparam logic [3:0] TK_HOOK    = 4'd5;
  localparam logic [3:0] TK_STR     = 4'd6;
  localparam logic [3:0] TK_STRBYTE = 4'd7;
  localparam logic [3:0] TK_ARR     = 4'd8;
  localparam logic [3:0] TK_END     = 4'd10;
  localparam logic [3:0] TK_DONE    = 4'd11;
  localparam logic [3:0] TK_ERROR   = 4'd12;

  // error codes
  localparam logic [2:0] ERR_UNEXP_END = 3'd1;
  localparam logic [2:0] ERR_TRUNC     = 3'd2;
  localparam logic [2:0] ERR_STRAY     = 3'd3;
  localparam logic [2:0] ERR_DEEP      = 3'd4;
  localparam logic [2:0] ERR_LEN       = 3'd5;

  localparam logic [63:0] FLT_M1 = 64'hBFF0000000000000;
  localparam logic [63:0] FLT_P1 = 64'h3FF0000000000000;

  typedef enum logic [3:0] {
    C_NONE, C_ACCEPT, C_STEP, C_END0, C_VD_RD, C_VD_CHK,
    C_SC_RD, C_SC_CHK, C_EOB, C_EOBL, C_FIN
  } cmd_e;

  typedef enum logic [1:0] {
    NX_NONE, NX_VD, NX_END0, NX_SCAN
  } next_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    next_e nx;
    logic  out_free;
    logic  dep_zero;
    logic  vd_stop;
    logic  scan_zero;
    logic  caught;
    logic  mode_type;
    logic  fin;
    logic  eob;
  } stat_t;

  // payload byte count for a payload kind
  function automatic logic [3:0] pay_size(input logic [3:0] kind);
    logic [3:0] s;
    s = 4'd8;
    if (kind <= 4'd3) s = 4'd1 << kind[1:0];
    else if (kind >= 4'd5 && kind <= 4'd8) s = 4'd1 << 2'(kind - 4'd5);
    return s;
  endfunction

endpackage

// ----- rtl/qpack_token_decoder_top.sv -----
// Token decoder for one serialized value, fed a byte per input beat.
// Input channel (in_valid_i/in_ready_o): opcode_i 0 carries data_byte_i,
// opcode_i 1 marks end of buffer; that beat emits the closing tokens plus
// a done or error token, then clears the parser for the next buffer.
// Output channel (out_valid_o/out_ready_i): one token per beat; last_o
// flags the final token caused by an input beat. Beats that cause no
// token (payload bytes, ignored trailing bytes) produce nothing.
// Throughput: one input beat at a time. A byte goes through accept, step
// and finish; a completed value adds a value-done step, and every frame
// closed or scanned adds a read and a check step on the frame stack memory.
// A token is held until the next token or the end of the beat is known,
// so that last_o is known, then goes to the output register; the next input
// beat can be accepted while the final token of the previous one waits there.
// Receiver stall: past the idle state, the sequencer holds whenever the
// output register is full and not being taken; nothing is lost. Reset
// (rst_ni low, async) empties the stack, clears pending tokens and
// returns to the type-byte state.
module qpack_token_decoder_top #(
  parameter int MAX_DEPTH = 16,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         token_kind_o,
  output logic signed [63:0] value_o,
  output logic [30:0]        length_o,
  output logic               open_ended_o,
  output logic [DW-1:0]      depth_o,
  output logic [DW-1:0]      dropped_frames_o,
  output logic [2:0]         error_code_o,
  output logic               last_o
);

  qtd_pkg::cmd_t  cmd;
  qtd_pkg::stat_t stat;

  // sequencer: walks byte step, frame unwinds and scans
  qtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // parser registers, frame stack and token output registers
  qtd_datapath #(
    .MAX_DEPTH (MAX_DEPTH),
    .DW        (DW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .opcode_i         (opcode_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .token_kind_o     (token_kind_o),
    .value_o          (value_o),
    .length_o         (length_o),
    .open_ended_o     (open_ended_o),
    .depth_o          (depth_o),
    .dropped_frames_o (dropped_frames_o),
    .error_code_o     (error_code_o),
    .last_o           (last_o)
  );

endmodule

// ----- rtl/qtd_datapath.sv -----
module qtd_datapath #(
  parameter int MAX_DEPTH = 16,
  parameter int DW = $clog2(MAX_DEPTH + 1),
  parameter int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qtd_pkg::cmd_t      cmd_i,
  output qtd_pkg::stat_t     stat_o,
  input  logic               opcode_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         token_kind_o,
  output logic signed [63:0] value_o,
  output logic [30:0]        length_o,
  output logic               open_ended_o,
  output logic [DW-1:0]      depth_o,
  output logic [DW-1:0]      dropped_frames_o,
  output logic [2:0]         error_code_o,
  output logic               last_o
);

  logic          op_q;
  logic [7:0]    byte_q;
  logic [1:0]    mode_q, mode_d;
  logic [3:0]    left_q, left_d;
  logic [3:0]    kind_q, kind_d;
  logic [63:0]   acc_q, acc_d;
  logic [30:0]   str_q, str_d;
  logic [DW-1:0] dep_q, dep_d;
  logic          fin_q, fin_d;
  logic [DW-1:0] scan_q, scan_d;
  logic [1:0]    seek_q, seek_d;
  logic [5:0]    rd_q;
  logic [5:0]    mem [MAX_DEPTH];

  logic          we;
  logic [AW-1:0] wa, ra;
  logic [5:0]    wd;

  // token being produced this cycle
  logic          emit;
  logic [3:0]    t_kind;
  logic [63:0]   t_val;
  logic [30:0]   t_len;
  logic          t_open;
  logic [DW-1:0] t_dep, t_drop;
  logic [2:0]    t_err;

  // held token, sent once the next one (or the end of the beat) is known
  logic          pv_q;
  logic [3:0]    p_kind;
  logic [63:0]   p_val;
  logic [30:0]   p_len;
  logic          p_open;
  logic [DW-1:0] p_dep, p_drop;
  logic [2:0]    p_err;

  logic          ov_q;
  logic          flush;
  logic          load;
  logic          caught;
  logic          rst_state;
  qtd_pkg::next_e nx;

  logic [DW-1:0] dm1, sm1;
  logic [3:0]    size, left, left_n;
  logic [2:0]    idx;
  logic [63:0]   acc_n, sx;
  logic [2:0]    cnt3;
  logic [3:0]    cnt_n;
  logic          is_map;
  logic          deep;

  assign dm1  = dep_q - DW'(1);
  assign sm1  = scan_q - DW'(1);
  assign deep = dep_q >= DW'(MAX_DEPTH);

  assign caught = (seek_q != qtd_pkg::SEEK_MAP && rd_q[5:4] == qtd_pkg::FK_OARR) ||
                  (seek_q != qtd_pkg::SEEK_ARR && rd_q[5:4] == qtd_pkg::FK_OMAP &&
                   !rd_q[0]);

  always_comb begin
    size   = qtd_pkg::pay_size(kind_q);
    left   = (left_q == 4'd0 || left_q > size) ? size : left_q;
    idx    = 3'(size - left);
    acc_n  = acc_q | ({56'd0, byte_q} << {idx, 3'b000});
    left_n = left - 4'd1;
    unique case (size)
      4'd1:    sx = {{56{acc_n[7]}}, acc_n[7:0]};
      4'd2:    sx = {{48{acc_n[15]}}, acc_n[15:0]};
      4'd4:    sx = {{32{acc_n[31]}}, acc_n[31:0]};
      default: sx = acc_n;
    endcase
  end

  always_comb begin
    mode_d = mode_q; left_d = left_q; kind_d = kind_q; acc_d = acc_q;
    str_d = str_q; dep_d = dep_q; fin_d = fin_q; scan_d = scan_q; seek_d = seek_q;
    emit = 1'b0; t_kind = qtd_pkg::TK_INT; t_val = '0; t_len = '0; t_open = 1'b0;
    t_dep = dep_q; t_drop = '0; t_err = '0;
    we = 1'b0; wa = dep_q[AW-1:0]; wd = '0; ra = dm1[AW-1:0];
    nx = qtd_pkg::NX_NONE; flush = 1'b0; rst_state = 1'b0;
    cnt3 = '0; cnt_n = '0; is_map = 1'b0;
    unique case (cmd_i.op)
      qtd_pkg::C_STEP: begin
        if (!fin_q) begin
          unique case (mode_q)
            qtd_pkg::MODE_TYPE: begin
              if (byte_q <= 8'd63) begin
                emit = 1'b1; t_val = {56'd0, byte_q}; nx = qtd_pkg::NX_VD;
              end else if (byte_q <= 8'd123) begin
                emit = 1'b1; t_val = 64'd63 - {56'd0, byte_q}; nx = qtd_pkg::NX_VD;
              end else if (byte_q == 8'd124) begin
                emit = 1'b1; t_kind = qtd_pkg::TK_HOOK; nx = qtd_pkg::NX_VD;
              end else if (byte_q <= 8'd127) begin
                emit = 1'b1; t_kind = qtd_pkg::TK_FLOAT; nx = qtd_pkg::NX_VD;
                case (byte_q[1:0])
                  2'd1:    t_val = qtd_pkg::FLT_M1;
                  2'd3:    t_val = qtd_pkg::FLT_P1;
                  default: t_val = '0;
                endcase
              end else if (byte_q <= 8'd227) begin
                emit = 1'b1; t_kind = qtd_pkg::TK_STR; t_len = 31'(byte_q - 8'd128);
                if (t_len == '0) begin
                  nx = qtd_pkg::NX_VD;
                end else begin
                  mode_d = qtd_pkg::MODE_STRING; str_d = t_len;
                end
              end else if (byte_q <= 8'd236) begin
                if (byte_q <= 8'd231) kind_d = 4'(byte_q - 8'd223);
                else if (byte_q <= 8'd235) kind_d = 4'(byte_q - 8'd232);
                else kind_d = 4'd4;
                left_d = qtd_pkg::pay_size(kind_d);
                acc_d  = '0;
                mode_d = qtd_pkg::MODE_PAYLOAD;
              end else if (byte_q <= 8'd248 || byte_q == 8'd252 || byte_q == 8'd253) begin
                if (byte_q <= 8'd242) begin
                  cnt3 = 3'(byte_q - 8'd237); is_map = 1'b0;
                end else if (byte_q <= 8'd248) begin
                  cnt3 = 3'(byte_q - 8'd243); is_map = 1'b1;
                end else begin
                  is_map = byte_q[0];
                end
                t_kind = qtd_pkg::TK_ARR + {3'd0, is_map};
                emit = 1'b1;
                if (byte_q <= 8'd248 && cnt3 == '0) begin
                  nx = qtd_pkg::NX_END0;
                end else if (deep) begin
                  t_kind = qtd_pkg::TK_ERROR; t_err = qtd_pkg::ERR_DEEP; t_dep = '0;
                  mode_d = qtd_pkg::MODE_ERROR; kind_d = {1'b0, qtd_pkg::ERR_DEEP};
                end else begin
                  we = 1'b1;
                  if (byte_q <= 8'd248) begin
                    t_len = 31'(cnt3);
                    wd = {{1'b0, is_map}, is_map ? {cnt3, 1'b0} : {1'b0, cnt3}};
                  end else begin
                    t_open = 1'b1;
                    wd = {{1'b1, is_map}, 4'd0};
                  end
                  dep_d = dep_q + DW'(1);
                end
              end else if (byte_q <= 8'd251) begin
                emit = 1'b1; t_kind = 4'(byte_q - 8'd247); nx = qtd_pkg::NX_VD;
              end else begin
                scan_d = dep_q;
                seek_d = byte_q[0] ? qtd_pkg::SEEK_MAP : qtd_pkg::SEEK_ARR;
                nx = qtd_pkg::NX_SCAN;
              end
            end
            qtd_pkg::MODE_PAYLOAD: begin
              acc_d = acc_n; left_d = left_n;
              if (left_n == 4'd0) begin
                mode_d = qtd_pkg::MODE_TYPE;
                emit = 1'b1;
                if (kind_q <= 4'd3) begin
                  t_val = sx; nx = qtd_pkg::NX_VD;
                end else if (kind_q == 4'd4) begin
                  t_kind = qtd_pkg::TK_FLOAT; t_val = acc_n; nx = qtd_pkg::NX_VD;
                end else if (acc_n[63:31] != '0) begin
                  t_kind = qtd_pkg::TK_ERROR; t_err = qtd_pkg::ERR_LEN; t_dep = '0;
                  mode_d = qtd_pkg::MODE_ERROR; kind_d = {1'b0, qtd_pkg::ERR_LEN};
                end else begin
                  t_kind = qtd_pkg::TK_STR; t_len = acc_n[30:0];
                  if (t_len == '0) begin
                    nx = qtd_pkg::NX_VD;
                  end else begin
                    mode_d = qtd_pkg::MODE_STRING; str_d = t_len;
                  end
                end
              end
            end
            qtd_pkg::MODE_STRING: begin
              emit = 1'b1; t_kind = qtd_pkg::TK_STRBYTE; t_val = {56'd0, byte_q};
              str_d = str_q - 31'd1;
              if (str_d == '0) begin
                mode_d = qtd_pkg::MODE_TYPE; nx = qtd_pkg::NX_VD;
              end
            end
            default: ;
          endcase
        end
      end
      qtd_pkg::C_END0: begin
        emit = 1'b1; t_kind = qtd_pkg::TK_END;
      end
      qtd_pkg::C_VD_RD: begin
        if (dep_q == '0) fin_d = 1'b1;
      end
      qtd_pkg::C_VD_CHK: begin
        wa = dm1[AW-1:0];
        cnt_n = rd_q[3:0] - 4'd1;
        if (rd_q[5:4] == qtd_pkg::FK_OMAP) begin
          we = 1'b1; wd = rd_q ^ 6'd1;
        end else if (rd_q[5:4] != qtd_pkg::FK_OARR) begin
          if (cnt_n != '0) begin
            we = 1'b1; wd = {rd_q[5:4], cnt_n};
          end else begin
            dep_d = dm1; emit = 1'b1; t_kind = qtd_pkg::TK_END; t_dep = dm1;
          end
        end
      end
      qtd_pkg::C_SC_RD: begin
        ra = sm1[AW-1:0];
        if (scan_q == '0) begin
          emit = 1'b1; t_kind = qtd_pkg::TK_ERROR; t_dep = '0;
          if (seek_q == qtd_pkg::SEEK_END) begin
            t_err = qtd_pkg::ERR_UNEXP_END;
          end else begin
            t_err = qtd_pkg::ERR_STRAY;
            mode_d = qtd_pkg::MODE_ERROR; kind_d = {1'b0, qtd_pkg::ERR_STRAY};
          end
        end
      end
      qtd_pkg::C_SC_CHK: begin
        if (caught) begin
          emit = 1'b1; t_kind = qtd_pkg::TK_END; t_open = 1'b1;
          t_dep = sm1; t_drop = dep_q - scan_q; dep_d = sm1;
        end else begin
          scan_d = sm1;
        end
      end
      qtd_pkg::C_EOB: begin
        if (mode_q == qtd_pkg::MODE_ERROR) begin
          emit = 1'b1; t_kind = qtd_pkg::TK_ERROR; t_err = kind_q[2:0]; t_dep = '0;
        end else if (mode_q != qtd_pkg::MODE_TYPE) begin
          emit = 1'b1; t_kind = qtd_pkg::TK_ERROR; t_err = qtd_pkg::ERR_TRUNC; t_dep = '0;
        end
      end
      qtd_pkg::C_EOBL: begin
        if (fin_q) begin
          emit = 1'b1; t_kind = qtd_pkg::TK_DONE; t_dep = '0;
        end else begin
          scan_d = dep_q; seek_d = qtd_pkg::SEEK_END;
        end
      end
      qtd_pkg::C_FIN: begin
        flush = 1'b1;
        rst_state = op_q;
      end
      default: ;
    endcase
    if (rst_state) begin
      mode_d = qtd_pkg::MODE_TYPE; left_d = '0; kind_d = '0; acc_d = '0;
      str_d = '0; dep_d = '0; fin_d = 1'b0;
    end
  end

  assign load = (emit && pv_q) || (flush && pv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qtd_pkg::MODE_TYPE;
      left_q <= '0;
      kind_q <= '0;
      acc_q  <= '0;
      str_q  <= '0;
      dep_q  <= '0;
      fin_q  <= 1'b0;
      scan_q <= '0;
      seek_q <= qtd_pkg::SEEK_ARR;
      pv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      left_q <= left_d;
      kind_q <= kind_d;
      acc_q  <= acc_d;
      str_q  <= str_d;
      dep_q  <= dep_d;
      fin_q  <= fin_d;
      scan_q <= scan_d;
      seek_q <= seek_d;
      if (emit) pv_q <= 1'b1;
      else if (flush) pv_q <= 1'b0;
      if (load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == qtd_pkg::C_ACCEPT) begin
      op_q   <= opcode_i;
      byte_q <= data_byte_i;
    end
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
    if (load) begin
      token_kind_o     <= p_kind;
      value_o          <= p_val;
      length_o         <= p_len;
      open_ended_o     <= p_open;
      depth_o          <= p_dep;
      dropped_frames_o <= p_drop;
      error_code_o     <= p_err;
      last_o           <= flush;
    end
    if (emit) begin
      p_kind <= t_kind; p_val <= t_val; p_len <= t_len; p_open <= t_open;
      p_dep  <= t_dep;  p_drop <= t_drop; p_err <= t_err;
    end
  end

  assign out_valid_o = ov_q;

  assign stat_o.nx        = nx;
  assign stat_o.out_free  = !ov_q || out_ready_i;
  assign stat_o.dep_zero  = dep_q == '0;
  assign stat_o.vd_stop   = rd_q[5:4] == qtd_pkg::FK_OARR || rd_q[5:4] == qtd_pkg::FK_OMAP ||
                            rd_q[3:0] != 4'd1;
  assign stat_o.scan_zero = scan_q == '0;
  assign stat_o.caught    = caught;
  assign stat_o.mode_type = mode_q == qtd_pkg::MODE_TYPE;
  assign stat_o.fin       = fin_q;
  assign stat_o.eob       = op_q;

endmodule

// ----- rtl/qtd_ctrl.sv -----
module qtd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qtd_pkg::stat_t stat_i,
  output qtd_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BYTE = 4'd1;
  localparam logic [3:0] S_END0 = 4'd2;
  localparam logic [3:0] S_VDR  = 4'd3;
  localparam logic [3:0] S_VDC  = 4'd4;
  localparam logic [3:0] S_SCR  = 4'd5;
  localparam logic [3:0] S_SCC  = 4'd6;
  localparam logic [3:0] S_EOB  = 4'd7;
  localparam logic [3:0] S_EOBL = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_q, state_d;
  logic [3:0] after_vd;

  assign in_ready_o = state_q == S_IDLE;
  assign after_vd   = stat_i.eob ? S_EOBL : S_FIN;

  always_comb begin
    state_d  = state_q;
    cmd_o.op = qtd_pkg::C_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = qtd_pkg::C_ACCEPT;
          state_d  = S_BYTE;
        end
      end
      default: begin
        if (stat_i.out_free) begin
          unique case (state_q)
            S_BYTE: begin
              if (stat_i.eob) begin
                state_d = S_EOB;
              end else begin
                cmd_o.op = qtd_pkg::C_STEP;
                unique case (stat_i.nx)
                  qtd_pkg::NX_VD:   state_d = S_VDR;
                  qtd_pkg::NX_END0: state_d = S_END0;
                  qtd_pkg::NX_SCAN: state_d = S_SCR;
                  default:          state_d = S_FIN;
                endcase
              end
            end
            S_END0: begin
              cmd_o.op = qtd_pkg::C_END0;
              state_d  = S_VDR;
            end
            S_VDR: begin
              cmd_o.op = qtd_pkg::C_VD_RD;
              state_d  = stat_i.dep_zero ? after_vd : S_VDC;
            end
            S_VDC: begin
              cmd_o.op = qtd_pkg::C_VD_CHK;
              state_d  = stat_i.vd_stop ? after_vd : S_VDR;
            end
            S_SCR: begin
              cmd_o.op = qtd_pkg::C_SC_RD;
              state_d  = stat_i.scan_zero ? S_FIN : S_SCC;
            end
            S_SCC: begin
              cmd_o.op = qtd_pkg::C_SC_CHK;
              state_d  = stat_i.caught ? S_VDR : S_SCR;
            end
            S_EOB: begin
              cmd_o.op = qtd_pkg::C_EOB;
              state_d  = stat_i.mode_type ? S_EOBL : S_FIN;
            end
            S_EOBL: begin
              cmd_o.op = qtd_pkg::C_EOBL;
              state_d  = stat_i.fin ? S_FIN : S_SCR;
            end
            S_FIN: begin
              cmd_o.op = qtd_pkg::C_FIN;
              state_d  = S_IDLE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule
